// ===== rtl/core/mmt_pkg.sv =====
package mmt_pkg;

  // field widths
  localparam int COORD_W  = 16;
  localparam int POS_IN_W = 17;
  localparam int FRAME_W  = 8;
  localparam int COUNT_W  = 3;
  localparam int SPEED_W  = 21;
  localparam int PRED_W   = 18;

  // fixed point: positions in 1/16 px, velocity in 1/256 px per frame
  localparam int SUB_BITS = 4;

  // limits
  localparam int MAX_STORED_DEF = 5;
  localparam int JUMP_LIMIT     = 320;
  localparam int SPEED_LIMIT    = 1280;
  localparam int LOST_RESET     = 10;
  localparam int PRED_MAX       = 131071;
  localparam int PRED_MIN       = -131072;

  // divider and product sizes
  localparam int DIV_W  = COORD_W + SUB_BITS;
  localparam int PROD_W = SPEED_W + FRAME_W + 1;

  localparam int QUEUE_DEPTH = 2;

  localparam logic MODE_OFFER   = 1'b0;
  localparam logic MODE_PREDICT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [FRAME_W-1:0] frame;
    logic               pos_ok;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
  } cmd_t;

endpackage

// ===== rtl/core/mmt_item_if.sv =====
interface mmt_item_if
  import mmt_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [FRAME_W-1:0]         frame_number;
  logic                       pos_valid;
  logic signed [POS_IN_W-1:0] pos_x;
  logic signed [POS_IN_W-1:0] pos_y;

  modport source (
    output valid, mode, frame_number, pos_valid, pos_x, pos_y,
    input  ready
  );

  modport sink (
    input  valid, mode, frame_number, pos_valid, pos_x, pos_y,
    output ready
  );
endinterface

// ===== rtl/core/mmt_result_if.sv =====
interface mmt_result_if
  import mmt_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     accepted;
  logic                     tracking;
  logic signed [PRED_W-1:0] pred_x;
  logic signed [PRED_W-1:0] pred_y;

  modport source (
    output valid, accepted, tracking, pred_x, pred_y,
    input  ready
  );

  modport sink (
    input  valid, accepted, tracking, pred_x, pred_y,
    output ready
  );
endinterface

// ===== rtl/core/marker_motion_tracker_core.sv =====
// an input transfer enters the command queue and is popped into the evaluate state; the
// result is registered there for an offer with no velocity update, after the predict state
// for a prediction, or when the 20-step serial velocity divider ends for a velocity offer
// a 2-entry command queue lets input transfers continue while the back end works
// rst is synchronous: track cleared, not tracked, lost limit back to 10, queue and result empty
module marker_motion_tracker_core
  import mmt_pkg::*;
#(
  parameter int MAX_STORED = MAX_STORED_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  mmt_item_if.sink           item,
  mmt_result_if.source       result
);

  // front end to queue
  logic q_push;
  cmd_t q_push_data;
  logic q_full;

  // queue to back end
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  // front end: takes input transfers whenever the queue has room and
  // flags offers that carry no usable position (missing or negative)
  mmt_front u_front (
    .item      (item),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // short command queue, decouples input transfers from execution
  mmt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  // back end: owns the track state and the lost limit register
  // offers: jump check, then two serial dividers for the velocity per axis
  // predictions: age the track, multiply by the gap per axis, then add and saturate
  // a command is popped only when the result register is free or being drained,
  // so a finished result is never overwritten
  mmt_exec #(
    .MAX_STORED (MAX_STORED)
  ) u_exec (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .result      (result)
  );

endmodule

// ===== rtl/core/mmt_div.sv =====
module mmt_div
  import mmt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [FRAME_W-1:0] divisor,
  output logic               busy,
  output logic [DIV_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [CNT_W-1:0]   cnt;
  logic [FRAME_W-1:0] rem;
  logic [FRAME_W-1:0] dvs;
  logic [DIV_W-1:0]   quo;
  logic [FRAME_W:0]   trial;
  logic               ge;

  // restoring step, one quotient bit per cycle
  assign trial = {rem, quo[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(DIV_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      rem <= ge ? FRAME_W'(trial - {1'b0, dvs}) : trial[FRAME_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/core/mmt_front.sv =====
module mmt_front
  import mmt_pkg::*;
(
  mmt_item_if.sink item,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_data
);

  assign item.ready = !q_full;
  assign push       = item.valid && item.ready;

  // a negative coordinate or a missing detection can never be stored
  always_comb begin
    push_data.mode   = item.mode;
    push_data.frame  = item.frame_number;
    push_data.pos_ok = item.pos_valid && !item.pos_x[POS_IN_W-1] && !item.pos_y[POS_IN_W-1];
    push_data.pos_x  = item.pos_x[COORD_W-1:0];
    push_data.pos_y  = item.pos_y[COORD_W-1:0];
  end

endmodule

// ===== rtl/core/mmt_queue.sv =====
module mmt_queue
  import mmt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  output logic valid,
  output cmd_t head,
  input  logic pop
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/mmt_exec.sv =====
module mmt_exec
  import mmt_pkg::*;
#(
  parameter int MAX_STORED = MAX_STORED_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [FRAME_W-1:0] cfg_wr_data,
  input  logic               q_valid,
  input  cmd_t               q_head,
  output logic               q_pop,
  mmt_result_if.source       result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PRED = 2'd3;

  localparam int SUM_W = PROD_W - SUB_BITS + 1;

  logic [1:0] state;

  // track state
  logic [FRAME_W-1:0]        lost_after_frames;
  logic [COORD_W-1:0]        last_x;
  logic [COORD_W-1:0]        last_y;
  logic [FRAME_W-1:0]        last_frame;
  logic [COUNT_W-1:0]        stored_count;
  logic signed [SPEED_W-1:0] speed_x;
  logic signed [SPEED_W-1:0] speed_y;
  logic                      tracked;

  // per item
  cmd_t                     cmd;
  logic                     neg_x;
  logic                     neg_y;
  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;

  // result register
  logic                     res_valid;
  logic                     res_accepted;
  logic                     res_tracking;
  logic signed [PRED_W-1:0] res_pred_x;
  logic signed [PRED_W-1:0] res_pred_y;

  logic [FRAME_W-1:0]        gap;
  logic [FRAME_W-1:0]        gap_div;
  logic signed [COORD_W:0]   dx;
  logic signed [COORD_W:0]   dy;
  logic [COORD_W-1:0]        mag_x;
  logic [COORD_W-1:0]        mag_y;
  logic                      vel_case;
  logic                      jump;
  logic                      take;
  logic                      keep;
  logic signed [SPEED_W-1:0] age_x;
  logic signed [SPEED_W-1:0] age_y;
  logic                      div_start;
  logic                      busy_x;
  logic                      busy_y;
  logic [DIV_W-1:0]          quo_x;
  logic [DIV_W-1:0]          quo_y;
  logic                      fin_offer;
  logic                      fin_div;
  logic                      fin_pred;
  logic                      commit;

  function automatic logic signed [SPEED_W-1:0] clamp_speed(
    input logic [DIV_W-1:0] q,
    input logic             neg
  );
    logic signed [SPEED_W-1:0] v;
    v = $signed(SPEED_W'(q));
    if (neg) begin
      v = -v;
    end
    if (v > $signed(SPEED_W'(SPEED_LIMIT))) begin
      v = $signed(SPEED_W'(SPEED_LIMIT));
    end
    return v;
  endfunction

  // last + prod / 16 truncated toward zero, saturated to the output range
  function automatic logic signed [PRED_W-1:0] predict(
    input logic [COORD_W-1:0]     last,
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0]          adj;
    logic signed [PROD_W-SUB_BITS-1:0] quo;
    logic signed [SUM_W-1:0]           sum;
    adj = prod + (prod[PROD_W-1] ? PROD_W'((1 << SUB_BITS) - 1) : '0);
    quo = $signed(adj[PROD_W-1:SUB_BITS]);
    sum = $signed({{(SUM_W-COORD_W){1'b0}}, last}) + $signed({quo[PROD_W-SUB_BITS-1], quo});
    if (sum > $signed(SUM_W'(PRED_MAX))) begin
      return $signed(PRED_W'(PRED_MAX));
    end else if (sum < $signed(SUM_W'(PRED_MIN))) begin
      return $signed(PRED_W'(PRED_MIN));
    end
    return sum[PRED_W-1:0];
  endfunction

  always_comb begin
    gap      = cmd.frame - last_frame;
    gap_div  = (gap == '0) ? FRAME_W'(1) : gap;
    dx       = $signed({1'b0, cmd.pos_x}) - $signed({1'b0, last_x});
    dy       = $signed({1'b0, cmd.pos_y}) - $signed({1'b0, last_y});
    mag_x    = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    mag_y    = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    vel_case = cmd.pos_ok && stored_count != '0 && last_x != '0 && last_y != '0;
    jump     = vel_case && (dx > $signed((COORD_W+1)'(JUMP_LIMIT)) ||
                            dy > $signed((COORD_W+1)'(JUMP_LIMIT)));
    take     = cmd.pos_ok && !jump;
    keep     = tracked && gap < lost_after_frames;
    age_x    = keep ? speed_x : '0;
    age_y    = keep ? speed_y : '0;
  end

  assign q_pop     = state == S_IDLE && q_valid && (!res_valid || result.ready);
  assign div_start = state == S_EVAL && cmd.mode == MODE_OFFER && vel_case && !jump;
  assign fin_offer = state == S_EVAL && cmd.mode == MODE_OFFER && !div_start;
  assign fin_div   = state == S_DIV && !busy_x && !busy_y;
  assign fin_pred  = state == S_PRED;
  assign commit    = (fin_offer && take) || fin_div;

  mmt_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag_x, SUB_BITS'(0)}),
    .divisor  (gap_div),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  mmt_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mag_y, SUB_BITS'(0)}),
    .divisor  (gap_div),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      lost_after_frames <= FRAME_W'(LOST_RESET);
      last_x            <= '0;
      last_y            <= '0;
      last_frame        <= '0;
      stored_count      <= '0;
      speed_x           <= '0;
      speed_y           <= '0;
      tracked           <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lost_after_frames <= cfg_wr_data;
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (cmd.mode == MODE_PREDICT) begin
            state   <= S_PRED;
            tracked <= keep;
            if (!keep) begin
              speed_x      <= '0;
              speed_y      <= '0;
              stored_count <= '0;
            end
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (fin_div) begin
            state   <= S_IDLE;
            speed_x <= clamp_speed(quo_x, neg_x);
            speed_y <= clamp_speed(quo_y, neg_y);
          end
        end
        S_PRED: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (commit) begin
        if (stored_count < COUNT_W'(MAX_STORED)) begin
          stored_count <= stored_count + COUNT_W'(1);
        end
        last_x     <= cmd.pos_x;
        last_y     <= cmd.pos_y;
        last_frame <= cmd.frame;
        tracked    <= 1'b1;
      end

      if (fin_offer || fin_div || fin_pred) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (div_start) begin
      neg_x <= dx[COORD_W];
      neg_y <= dy[COORD_W];
    end
    if (state == S_EVAL) begin
      prod_x <= PROD_W'(age_x) * PROD_W'($signed({1'b0, gap}));
      prod_y <= PROD_W'(age_y) * PROD_W'($signed({1'b0, gap}));
    end
    if (fin_offer) begin
      res_accepted <= take;
      res_tracking <= take || tracked;
      res_pred_x   <= '0;
      res_pred_y   <= '0;
    end else if (fin_div) begin
      res_accepted <= 1'b1;
      res_tracking <= 1'b1;
      res_pred_x   <= '0;
      res_pred_y   <= '0;
    end else if (fin_pred) begin
      res_accepted <= 1'b0;
      res_tracking <= tracked;
      res_pred_x   <= predict(last_x, prod_x);
      res_pred_y   <= predict(last_y, prod_y);
    end
  end

  assign result.valid    = res_valid;
  assign result.accepted = res_accepted;
  assign result.tracking = res_tracking;
  assign result.pred_x   = res_pred_x;
  assign result.pred_y   = res_pred_y;

endmodule

// ===== rtl/core/mmt_checker.sv =====
module mmt_checker
  import mmt_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     item_valid,
  input logic                     item_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic                     res_accepted,
  input logic                     res_tracking,
  input logic signed [PRED_W-1:0] res_pred_x,
  input logic signed [PRED_W-1:0] res_pred_y
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_accepted) &&
      $stable(res_tracking) && $stable(res_pred_x) && $stable(res_pred_y))
    else $error("result changed while stalled");

  // a stored position always leaves the track active
  a_acc_track: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_accepted |-> res_tracking)
    else $error("accepted without tracking");

  // accepted offers carry no prediction
  a_acc_pred: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_accepted |-> res_pred_x == '0 && res_pred_y == '0)
    else $error("prediction on an accepted offer");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // a transfer taken in the first cycle out of reset gives no result in the cycle after it
  a_rst_ready: assert property (@(posedge clk)
    !rst && $past(rst) && item_valid && item_ready |=> !res_valid)
    else $error("result too early after reset");

endmodule

bind marker_motion_tracker_core mmt_checker u_mmt_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_accepted (result.accepted),
  .res_tracking (result.tracking),
  .res_pred_x   (result.pred_x),
  .res_pred_y   (result.pred_y)
);
